[rtl/bgr_pkg.sv]
// shared types and constants for the button gesture recognizer
`timescale 1ns / 1ps
`default_nettype none

package bgr_pkg;

  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned EVENT_W   = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [STAMP_W-1:0]    stamp_t;
  typedef logic [MS_W-1:0]       ms_t;
  typedef logic [EVENT_W-1:0]    event_code_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // event codes
  localparam event_code_t EV_NONE  = 3'd0;
  localparam event_code_t EV_CLICK = 3'd1;
  localparam event_code_t EV_DBL   = 3'd2;
  localparam event_code_t EV_LONG  = 3'd3;
  localparam event_code_t EV_VLONG = 3'd4;

  // register indexes
  localparam cfg_idx_t CFG_ENABLE        = 3'd0;
  localparam cfg_idx_t CFG_PULL_MODE     = 3'd1;
  localparam cfg_idx_t CFG_DEBOUNCE_MS   = 3'd2;
  localparam cfg_idx_t CFG_DBL_CLICK_MS  = 3'd3;
  localparam cfg_idx_t CFG_LONG_MS       = 3'd4;
  localparam cfg_idx_t CFG_VLONG_MS      = 3'd5;
  localparam cfg_idx_t CFG_VLONG_ON_HOLD = 3'd6;

  // register reset values
  localparam ms_t DEBOUNCE_RST  = 16'd40;
  localparam ms_t DBL_CLICK_RST = 16'd250;
  localparam ms_t LONG_RST      = 16'd750;
  localparam ms_t VLONG_RST     = 16'd3000;

endpackage

`default_nettype wire

[rtl/bgr_if.sv]
// channel interfaces: sample input, result output, register writes
`timescale 1ns / 1ps
`default_nettype none

interface bgr_in_if;
  import bgr_pkg::*;
  logic   valid;
  logic   ready;
  stamp_t now_ms;
  logic   level;
  modport source (output valid, output now_ms, output level, input ready);
  modport sink   (input valid, input now_ms, input level, output ready);
endinterface

interface bgr_out_if;
  import bgr_pkg::*;
  logic        valid;
  logic        ready;
  event_code_t event_res;
  logic        busy_res;
  modport source (output valid, output event_res, output busy_res, input ready);
  modport sink   (input valid, input event_res, input busy_res, output ready);
endinterface

interface bgr_cfg_if;
  import bgr_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/button_gesture_recognizer.sv]
// button gesture recognizer: click, double click, long and very long press
// result: registered in the output register, valid in the cycle after the transfer
// throughput: one sample per cycle unless a full output register is stalled;
//   the gesture state update and the output register both close in the cycle of the transfer
// reset: synchronous; registers return to their defaults (block disabled),
//   gesture state to released with both stamps all ones, output empty
`timescale 1ns / 1ps
`default_nettype none

module button_gesture_recognizer (
  input  wire       clk,
  input  wire       rst,
  bgr_in_if.sink    sample,
  bgr_out_if.source result,
  bgr_cfg_if.sink   cfg
);
  import bgr_pkg::*;

  // configuration registers
  logic enable;
  logic pull_mode;
  ms_t  debounce_ms;
  ms_t  dbl_click_ms;
  ms_t  long_ms;
  ms_t  vlong_ms;
  logic vlong_on_hold;

  // gesture state
  logic   last_pressed, last_pressed_next;
  stamp_t down_stamp, down_stamp_next;
  stamp_t up_stamp, up_stamp_next;
  logic   dbl_waiting, dbl_waiting_next;
  logic   dbl_on_next_up, dbl_on_next_up_next;
  logic   single_ok, single_ok_next;
  logic   ignore_release, ignore_release_next;
  logic   long_done, long_done_next;
  logic   vlong_done, vlong_done_next;
  logic   busy_flag, busy_flag_next;

  // output register
  logic        out_valid;
  event_code_t out_event;
  logic        out_busy;

  logic        in_xfer;
  logic        pressed;
  stamp_t      since_up, since_down;
  stamp_t      since_up2, since_down2;
  event_code_t ev;

  assign cfg.ready    = 1'b1;
  assign sample.ready = !out_valid || result.ready;
  assign in_xfer      = sample.valid && sample.ready;

  assign result.valid     = out_valid;
  assign result.event_res = out_event;
  assign result.busy_res  = out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      pull_mode     <= 1'b1;
      debounce_ms   <= DEBOUNCE_RST;
      dbl_click_ms  <= DBL_CLICK_RST;
      long_ms       <= LONG_RST;
      vlong_ms      <= VLONG_RST;
      vlong_on_hold <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ENABLE:        enable        <= cfg.data[0];
        CFG_PULL_MODE:     pull_mode     <= cfg.data[0];
        CFG_DEBOUNCE_MS:   debounce_ms   <= cfg.data;
        CFG_DBL_CLICK_MS:  dbl_click_ms  <= cfg.data;
        CFG_LONG_MS:       long_ms       <= cfg.data;
        CFG_VLONG_MS:      vlong_ms      <= cfg.data;
        CFG_VLONG_ON_HOLD: vlong_on_hold <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    last_pressed_next   = last_pressed;
    down_stamp_next     = down_stamp;
    up_stamp_next       = up_stamp;
    dbl_waiting_next    = dbl_waiting;
    dbl_on_next_up_next = dbl_on_next_up;
    single_ok_next      = single_ok;
    ignore_release_next = ignore_release;
    long_done_next      = long_done;
    vlong_done_next     = vlong_done;
    busy_flag_next      = busy_flag;
    ev                  = EV_NONE;

    pressed    = (sample.level != pull_mode);
    since_up   = sample.now_ms - up_stamp;
    since_down = sample.now_ms - down_stamp;
    since_up2   = since_up;
    since_down2 = since_down;

    // debounced press and release edges
    if (pressed && !last_pressed && (since_up > {16'd0, debounce_ms})) begin
      down_stamp_next     = sample.now_ms;
      since_down2         = '0;
      ignore_release_next = 1'b0;
      single_ok_next      = 1'b1;
      long_done_next      = 1'b0;
      vlong_done_next     = 1'b0;
      dbl_on_next_up_next = (since_up < {16'd0, dbl_click_ms}) && !dbl_on_next_up
                            && dbl_waiting;
      dbl_waiting_next    = 1'b0;
      busy_flag_next      = 1'b1;
    end else if (!pressed && last_pressed && (since_down > {16'd0, debounce_ms})) begin
      if (!ignore_release) begin
        up_stamp_next = sample.now_ms;
        since_up2     = '0;
        if (!dbl_on_next_up) begin
          dbl_waiting_next = 1'b1;
        end else begin
          ev                  = EV_DBL;
          dbl_on_next_up_next = 1'b0;
          dbl_waiting_next    = 1'b0;
          single_ok_next      = 1'b0;
        end
      end
    end

    // single click once the double-click window has run out
    if (!pressed && (since_up2 >= {16'd0, dbl_click_ms}) && dbl_waiting_next
        && !dbl_on_next_up_next && single_ok_next && (ev != EV_DBL)) begin
      ev               = EV_CLICK;
      dbl_waiting_next = 1'b0;
    end

    if (!pressed && long_done_next && !vlong_done_next) begin
      ev             = EV_LONG;
      long_done_next = 1'b0;
    end

    if (!pressed && vlong_done_next) begin
      ev              = EV_VLONG;
      vlong_done_next = 1'b0;
      long_done_next  = 1'b0;
    end

    // hold thresholds while pressed
    if (pressed && (since_down2 >= {16'd0, long_ms})) begin
      if (!long_done_next) begin
        ignore_release_next = 1'b1;
        dbl_on_next_up_next = 1'b0;
        dbl_waiting_next    = 1'b0;
        long_done_next      = 1'b1;
      end
      if ((since_down2 >= {16'd0, vlong_ms}) && !vlong_done_next) begin
        if (vlong_on_hold) begin
          ev = EV_VLONG;
        end
        vlong_done_next = 1'b1;
      end
    end

    last_pressed_next = pressed;
    if (ev != EV_NONE) begin
      busy_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pressed   <= 1'b0;
      down_stamp     <= '1;
      up_stamp       <= '1;
      dbl_waiting    <= 1'b0;
      dbl_on_next_up <= 1'b0;
      single_ok      <= 1'b1;
      ignore_release <= 1'b1;
      long_done      <= 1'b0;
      vlong_done     <= 1'b0;
      busy_flag      <= 1'b0;
    end else if (in_xfer && enable) begin
      last_pressed   <= last_pressed_next;
      down_stamp     <= down_stamp_next;
      up_stamp       <= up_stamp_next;
      dbl_waiting    <= dbl_waiting_next;
      dbl_on_next_up <= dbl_on_next_up_next;
      single_ok      <= single_ok_next;
      ignore_release <= ignore_release_next;
      long_done      <= long_done_next;
      vlong_done     <= vlong_done_next;
      busy_flag      <= busy_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_event <= enable ? ev : EV_NONE;
      out_busy  <= enable && busy_flag_next;
    end
  end

  // any raised event clears busy in the same result
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_event != EV_NONE)) |-> !out_busy)
    else $error("event raised with busy set");

  // a disabled block gives an empty result
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !enable) |=> ((out_event == EV_NONE) && !out_busy))
    else $error("disabled block produced an event");

  // very long press is only reached through a long press
  assert property (@(posedge clk) disable iff (rst)
    vlong_done |-> long_done)
    else $error("very long flag without long flag");

  // gesture state is frozen while disabled
  assert property (@(posedge clk) disable iff (rst)
    !enable |=> ($stable(down_stamp) && $stable(up_stamp) && $stable(busy_flag)))
    else $error("state changed while disabled");

endmodule

`default_nettype wire

[test/tb.sv]
// testbench for the button gesture recognizer: directed table, then random gestures
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import bgr_pkg::*;

  localparam cfg_idx_t    CFG_UNUSED   = 3'd7;  // no register behind this index
  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct packed {
    event_code_t ev;
    logic        busy;
  } gesture_t;

  typedef struct packed {
    logic        typed;
    event_code_t ev;
    logic        busy;
  } typed_t;

  typedef enum logic {ROW_SMP, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_idx_t    idx;
    stamp_t      val;
    logic        lvl;
    logic        typed;
    event_code_t ev;
    logic        busy;
  } row_t;

  logic clk;
  logic rst;
  logic take_res = 1'b0;

  bgr_in_if  smp_if ();
  bgr_out_if res_if ();
  bgr_cfg_if cfg_if ();

  assign res_if.ready = take_res;

  button_gesture_recognizer i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (smp_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  // register mirror
  logic cf_enable, cf_pull, cf_vlong_hold;
  ms_t  cf_debounce, cf_dbl, cf_long, cf_vlong;

  // gesture state
  logic   held, dbl_armed, dbl_pending, click_ok;
  logic   skip_release, long_seen, vlong_seen, gesture_busy;
  stamp_t press_at, release_at;

  gesture_t    gesture_q[$];
  typed_t      typed_q[$];
  int unsigned mismatches = 0;
  int unsigned sent = 0;
  int unsigned out_stall = 0;
  bit          gaps_on = 1'b0;
  bit          stalls_on = 1'b0;
  stamp_t      clock_ms;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic gesture_t step_gesture(stamp_t t, logic lv);
    gesture_t    o;
    logic        pressed;
    stamp_t      since_up;
    stamp_t      since_down;
    event_code_t ev;
    ev = EV_NONE;
    o.ev = EV_NONE;
    o.busy = 1'b0;
    if (!cf_enable) return o;
    pressed = (lv != cf_pull);
    since_up = t - release_at;
    since_down = t - press_at;
    if (pressed && !held && since_up > stamp_t'(cf_debounce)) begin
      press_at = t;
      skip_release = 1'b0;
      click_ok = 1'b1;
      long_seen = 1'b0;
      vlong_seen = 1'b0;
      dbl_pending = (since_up < stamp_t'(cf_dbl)) && !dbl_pending && dbl_armed;
      dbl_armed = 1'b0;
      gesture_busy = 1'b1;
    end else if (!pressed && held && since_down > stamp_t'(cf_debounce)) begin
      if (!skip_release) begin
        release_at = t;
        if (!dbl_pending) begin
          dbl_armed = 1'b1;
        end else begin
          ev = EV_DBL;
          dbl_pending = 1'b0;
          dbl_armed = 1'b0;
          click_ok = 1'b0;
        end
      end
    end
    since_up = t - release_at;
    since_down = t - press_at;
    if (!pressed && since_up >= stamp_t'(cf_dbl) && dbl_armed && !dbl_pending
        && click_ok && ev != EV_DBL) begin
      ev = EV_CLICK;
      dbl_armed = 1'b0;
    end
    if (!pressed && long_seen && !vlong_seen) begin
      ev = EV_LONG;
      long_seen = 1'b0;
    end
    if (!pressed && vlong_seen) begin
      ev = EV_VLONG;
      vlong_seen = 1'b0;
      long_seen = 1'b0;
    end
    if (pressed && since_down >= stamp_t'(cf_long)) begin
      if (!long_seen) begin
        skip_release = 1'b1;
        dbl_pending = 1'b0;
        dbl_armed = 1'b0;
        long_seen = 1'b1;
      end
      if (since_down >= stamp_t'(cf_vlong) && !vlong_seen) begin
        if (cf_vlong_hold) ev = EV_VLONG;
        vlong_seen = 1'b1;
      end
    end
    held = pressed;
    if (ev != EV_NONE) gesture_busy = 1'b0;
    o.ev = ev;
    o.busy = gesture_busy;
    return o;
  endfunction

  // follow register writes and sample transfers, queue the expected results
  always @(posedge clk) begin
    gesture_t o;
    typed_t   h;
    if (rst) begin
      cf_enable = 1'b0;
      cf_pull = 1'b1;
      cf_debounce = DEBOUNCE_RST;
      cf_dbl = DBL_CLICK_RST;
      cf_long = LONG_RST;
      cf_vlong = VLONG_RST;
      cf_vlong_hold = 1'b1;
      held = 1'b0;
      press_at = '1;
      release_at = '1;
      dbl_armed = 1'b0;
      dbl_pending = 1'b0;
      click_ok = 1'b1;
      skip_release = 1'b1;
      long_seen = 1'b0;
      vlong_seen = 1'b0;
      gesture_busy = 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_ENABLE:        cf_enable = cfg_if.data[0];
          CFG_PULL_MODE:     cf_pull = cfg_if.data[0];
          CFG_DEBOUNCE_MS:   cf_debounce = cfg_if.data;
          CFG_DBL_CLICK_MS:  cf_dbl = cfg_if.data;
          CFG_LONG_MS:       cf_long = cfg_if.data;
          CFG_VLONG_MS:      cf_vlong = cfg_if.data;
          CFG_VLONG_ON_HOLD: cf_vlong_hold = cfg_if.data[0];
          default: ;
        endcase
      end
      if (smp_if.valid && smp_if.ready) begin
        o = step_gesture(smp_if.now_ms, smp_if.level);
        h = typed_q.pop_front();
        if (h.typed) begin
          o.ev = h.ev;
          o.busy = h.busy;
        end
        gesture_q.push_back(o);
      end
    end
  end

  // result side: random stalls, compare against the oldest expectation
  always @(posedge clk) begin
    gesture_t w;
    if (rst) begin
      take_res <= 1'b0;
      out_stall = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (gesture_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual event %0d busy %0d",
                   $time, res_if.event_res, res_if.busy_res);
        end else begin
          w = gesture_q.pop_front();
          if (res_if.event_res !== w.ev) begin
            mismatches++;
            $display("%0t: event mismatch, expected %0d actual %0d",
                     $time, w.ev, res_if.event_res);
          end
          if (res_if.busy_res !== w.busy) begin
            mismatches++;
            $display("%0t: busy mismatch, expected %0d actual %0d",
                     $time, w.busy, res_if.busy_res);
          end
        end
        out_stall = stalls_on ? $urandom_range(0, 3) : 0;
      end else if (out_stall != 0) begin
        out_stall--;
      end
      take_res <= (out_stall == 0);
    end
  end

  task automatic send_sample(stamp_t t, logic lv, logic typed, event_code_t ev, logic busy);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    typed_q.push_back('{typed, ev, busy});
    if (gap != 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp_if.valid  <= 1'b1;
    smp_if.now_ms <= t;
    smp_if.level  <= lv;
    do @(posedge clk); while (!smp_if.ready);
    sent++;
  endtask

  // registers change only once every outstanding result has come back
  task automatic write_reg(cfg_idx_t idx, cfg_data_t d);
    smp_if.valid <= 1'b0;
    do @(posedge clk); while (gesture_q.size() != 0);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic tick(int unsigned dt, logic lv);
    clock_ms = clock_ms + stamp_t'(dt);
    send_sample(clock_ms, lv, 1'b0, EV_NONE, 1'b0);
  endtask

  function automatic int unsigned span(int lo, int hi);
    if (hi <= lo) return lo;
    return $urandom_range(lo, hi);
  endfunction

  function automatic ms_t draw_ms(int unsigned typical, int unsigned phase);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (phase == 0 || r == 0) return '0;
    if (phase == 1 || r == 1) return '1;
    return ms_t'($urandom_range(0, typical));
  endfunction

  // press for hold ms, then stay released for gap ms, with a few samples in between
  task automatic press_for(int unsigned hold, int unsigned gap);
    int unsigned n;
    int unsigned part;
    n = $urandom_range(0, 3);
    part = hold / (n + 1);
    tick(0, ~cf_pull);
    repeat (n) tick(part, ~cf_pull);
    tick(hold - part * n, cf_pull);
    n = $urandom_range(0, 2);
    part = gap / (n + 1);
    repeat (n) tick(part, cf_pull);
    tick(gap - part * n, cf_pull);
  endtask

  task automatic play_gesture();
    int deb, win, lng, vl;
    int unsigned n;
    logic lv;
    deb = int'(cf_debounce);
    win = int'(cf_dbl);
    lng = int'(cf_long);
    vl = int'(cf_vlong);
    case ($urandom_range(0, 13))
      0, 1, 2: press_for(span(deb + 1, lng - 1), span(win, win + 400));
      3, 4, 5, 6: begin
        press_for(span(deb + 1, lng - 1), span(deb + 1, win - 1));
        press_for(span(deb + 1, lng - 1), span(win, win + 400));
      end
      7, 8: press_for(span(lng, vl), span(win, win + 400));
      9, 10: press_for(span(vl, vl + 300), span(0, win + 400));
      11: begin
        // contact chatter around the debounce time
        lv = cf_pull;
        n = $urandom_range(2, 6);
        repeat (n) begin
          lv = ~lv;
          tick(span(0, deb + 2), lv);
        end
      end
      default: begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) tick($urandom, 1'($urandom_range(0, 1)));
          else tick(span(0, 5000), 1'($urandom_range(0, 1)));
        end
      end
    endcase
  endtask

  initial begin
    int unsigned cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL button_gesture_recognizer");
    $finish;
  end

  initial begin
    row_t        plan[$];
    cfg_data_t   d;
    int unsigned phase;
    int unsigned phase_end;
    int unsigned base;

    rst = 1'b1;
    smp_if.valid  <= 1'b0;
    smp_if.now_ms <= '0;
    smp_if.level  <= 1'b0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= CFG_ENABLE;
    cfg_if.data   <= '0;

    // default pull-up: level 0 means pressed
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'h0000_0000, 1'b0, 1'b1, EV_NONE, 1'b0});
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'hFFFF_FFFF, 1'b1, 1'b1, EV_NONE, 1'b0});
    plan.push_back('{ROW_CFG, CFG_UNUSED, 32'h0000_FFFF, 1'b0, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_CFG, CFG_ENABLE, 32'h0000_0001, 1'b0, 1'b0, EV_NONE, 1'b0});
    // single click
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd100, 1'b0, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd200, 1'b1, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd460, 1'b1, 1'b1, EV_CLICK, 1'b0});
    // double click
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd1000, 1'b0, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd1100, 1'b1, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd1200, 1'b0, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd1300, 1'b1, 1'b1, EV_DBL, 1'b0});
    // long press, raised on release
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd2000, 1'b0, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd2750, 1'b0, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd2800, 1'b1, 1'b1, EV_LONG, 1'b0});
    // very long press while held and again on release
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd4000, 1'b0, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd7000, 1'b0, 1'b1, EV_VLONG, 1'b0});
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd7100, 1'b1, 1'b1, EV_VLONG, 1'b0});
    // press inside the debounce time after a release is dropped
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd8000, 1'b0, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd8100, 1'b1, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd8120, 1'b0, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd8130, 1'b1, 1'b0, EV_NONE, 1'b0});
    // disabled in the middle of a gesture: state holds, output is quiet
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd9000, 1'b0, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_CFG, CFG_ENABLE, 32'h0000_FFFE, 1'b0, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd9100, 1'b1, 1'b1, EV_NONE, 1'b0});
    plan.push_back('{ROW_CFG, CFG_ENABLE, 32'h0000_0001, 1'b0, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'd9200, 1'b1, 1'b0, EV_NONE, 1'b0});
    // pull-down, very long only on release, no debounce, time wraps during the hold
    plan.push_back('{ROW_CFG, CFG_PULL_MODE, 32'h0000_0000, 1'b0, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_CFG, CFG_VLONG_ON_HOLD, 32'h0000_0000, 1'b0, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_CFG, CFG_DEBOUNCE_MS, 32'h0000_0000, 1'b0, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'hFFFF_FFF0, 1'b1, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'h0000_0F00, 1'b1, 1'b0, EV_NONE, 1'b0});
    plan.push_back('{ROW_SMP, CFG_ENABLE, 32'h0000_1000, 1'b0, 1'b0, EV_NONE, 1'b0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_reg(plan[i].idx, cfg_data_t'(plan[i].val));
      else send_sample(plan[i].val, plan[i].lvl, plan[i].typed, plan[i].ev, plan[i].busy);
    end

    clock_ms = 32'h0000_2000;
    phase = 0;
    base = sent;
    while (sent < base + RANDOM_ITEMS) begin
      if (phase > 1) begin
        case ($urandom_range(0, 5))
          0: clock_ms = $urandom;
          1: clock_ms = 32'hFFFF_E000;
          default: ;
        endcase
      end
      d = cfg_data_t'($urandom);
      d[0] = (phase < 2) || ($urandom_range(0, 7) != 0);
      write_reg(CFG_ENABLE, d);
      write_reg(CFG_PULL_MODE, cfg_data_t'($urandom));
      write_reg(CFG_DEBOUNCE_MS, draw_ms(100, phase));
      write_reg(CFG_DBL_CLICK_MS, draw_ms(600, phase));
      write_reg(CFG_LONG_MS, draw_ms(1500, phase));
      write_reg(CFG_VLONG_MS, draw_ms(4000, phase));
      write_reg(CFG_VLONG_ON_HOLD, cfg_data_t'($urandom));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, cfg_data_t'($urandom));
      phase_end = sent + $urandom_range(30, 90);
      while (sent < phase_end) begin
        gaps_on = ($urandom_range(0, 2) != 0);
        stalls_on = ($urandom_range(0, 2) != 0);
        play_gesture();
      end
      phase++;
    end

    smp_if.valid <= 1'b0;
    do @(posedge clk); while (gesture_q.size() != 0);
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("PASS button_gesture_recognizer");
    else $display("FAIL button_gesture_recognizer");
    $finish;
  end

endmodule

`default_nettype wire
